FILE: hdl/timed_wait_delta_queue_defines.svh
// Assertion macros shared by the timer queue checker.
// Every macro samples on i_clk and is switched off while i_rst_n is low.
`ifndef TIMED_WAIT_DELTA_QUEUE_DEFINES_SVH
`define TIMED_WAIT_DELTA_QUEUE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TWDQ_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TWDQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/twdq_pkg.sv
// Package for the delta-list timer queue: request and result types,
// controller states, datapath commands and status. No dependencies.
`timescale 1ns / 1ps

package twdq_pkg;

    // Default sizing of the queue.
    localparam int QUEUE_DEPTH_DEF = 32;
    localparam int DELAY_BITS_DEF  = 16;

    // Fixed field widths of the request and the result.
    localparam int IN_DELAY_W = 16;
    localparam int COUNT_W    = 6;

    // Request kinds.
    localparam logic MODE_ADD  = 1'b0;
    localparam logic MODE_TICK = 1'b1;

    typedef struct packed {
        logic                  mode;
        logic [IN_DELAY_W-1:0] delay;
    } t_in_item;

    typedef struct packed {
        logic [COUNT_W-1:0] released;
        logic [COUNT_W-1:0] waiting;
        logic               rejected;
    } t_out_item;

    // Controller states.
    typedef enum logic [3:0] {
        S_IDLE,
        S_TICK_RD,
        S_TICK_CHK,
        S_SRCH_RD,
        S_SRCH_CHK,
        S_MOVE_RD,
        S_MOVE_WR,
        S_INS_HI,
        S_INS_LO,
        S_DONE
    } t_state;

    // Commands from the controller to the datapath.
    typedef enum logic [3:0] {
        DP_NOP,
        DP_LOAD,
        DP_TICK_RD,
        DP_TICK_CHK,
        DP_SRCH_RD,
        DP_SRCH_CHK,
        DP_MOVE_RD,
        DP_MOVE_WR,
        DP_INS_HI,
        DP_INS_LO,
        DP_FINISH
    } t_dp_op;

    // Status from the datapath back to the controller.
    typedef struct packed {
        logic empty;      // no live entries
        logic full;       // every slot is live
        logic tick_zero;  // head delta (decremented on the first read only) is zero
        logic last;       // exactly one live entry
        logic at_end;     // search index has passed the last live entry
        logic found;      // running deadline has reached the new deadline
        logic move_done;  // shift index has reached the slot after the insert slot
    } t_dp_status;

endpackage

FILE: hdl/twdq_ctrl.sv
// Controller state machine of the timer queue.
// Sequences the datapath commands and owns both handshakes; uses twdq_pkg.
`timescale 1ns / 1ps

module twdq_ctrl import twdq_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_mode,
    input  logic       i_out_stall,
    input  t_dp_status i_status,
    output logic       o_in_stall,
    output logic       o_out_valid,
    output t_dp_op     o_op
);

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;

    // State and result valid registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Next state and datapath command.
    always_comb begin
        n_state     = r_state;
        o_op        = DP_NOP;
        n_out_valid = r_out_valid & i_out_stall;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_op = DP_LOAD;
                    if (i_in_mode == MODE_TICK) begin
                        n_state = i_status.empty ? S_DONE : S_TICK_RD;
                    end else begin
                        n_state = i_status.full ? S_DONE : S_SRCH_RD;
                    end
                end
            end
            S_TICK_RD: begin
                o_op    = DP_TICK_RD;
                n_state = S_TICK_CHK;
            end
            S_TICK_CHK: begin
                o_op    = DP_TICK_CHK;
                n_state = (i_status.tick_zero && !i_status.last) ? S_TICK_RD : S_DONE;
            end
            S_SRCH_RD: begin
                o_op    = DP_SRCH_RD;
                n_state = i_status.at_end ? S_INS_LO : S_SRCH_CHK;
            end
            S_SRCH_CHK: begin
                o_op    = DP_SRCH_CHK;
                n_state = i_status.found ? S_MOVE_RD : S_SRCH_RD;
            end
            S_MOVE_RD: begin
                if (i_status.move_done) begin
                    n_state = S_INS_HI;
                end else begin
                    o_op    = DP_MOVE_RD;
                    n_state = S_MOVE_WR;
                end
            end
            S_MOVE_WR: begin
                o_op    = DP_MOVE_WR;
                n_state = S_MOVE_RD;
            end
            S_INS_HI: begin
                o_op    = DP_INS_HI;
                n_state = S_INS_LO;
            end
            S_INS_LO: begin
                o_op    = DP_INS_LO;
                n_state = S_DONE;
            end
            S_DONE: begin
                // Hand the result over once the output register is free.
                if (!r_out_valid || !i_out_stall) begin
                    o_op        = DP_FINISH;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

FILE: hdl/twdq_datapath.sv
// Datapath of the timer queue: the delta memory kept as a ring behind a head
// pointer, the entry count, search and shift indexes, and the result register.
// Uses twdq_pkg.
`timescale 1ns / 1ps

module twdq_datapath import twdq_pkg::*; #(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    parameter int DELAY_BITS  = DELAY_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_dp_op     i_op,
    input  t_in_item   i_in_data,
    output t_dp_status o_status,
    output t_out_item  o_out_data
);

    localparam int IDX_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int SUM_W = DELAY_BITS + 1;

    // Delta memory, one write and one registered read per cycle.
    logic [DELAY_BITS-1:0] mem [QUEUE_DEPTH];
    logic [DELAY_BITS-1:0] r_rdata;

    // Queue control state.
    logic [IDX_W-1:0] r_head;
    logic [CNT_W-1:0] r_count;

    // Per-request working registers.
    logic [CNT_W-1:0]      r_idx;
    logic [CNT_W-1:0]      r_pos;
    logic [CNT_W-1:0]      r_gone;
    logic [DELAY_BITS-1:0] r_d;
    logic [DELAY_BITS-1:0] r_before;
    logic [DELAY_BITS-1:0] r_sum;
    logic                  r_first;
    logic                  r_rejected;
    t_out_item             r_out;

    logic [DELAY_BITS-1:0] load_d;
    logic [DELAY_BITS-1:0] tick_val;
    logic [SUM_W-1:0]      sum;
    logic [CNT_W-1:0]      rd_l;
    logic [CNT_W-1:0]      wr_l;
    logic                  we;
    logic [DELAY_BITS-1:0] wd;
    logic [IDX_W-1:0]      rd_addr;
    logic [IDX_W-1:0]      wr_addr;
    logic [IDX_W-1:0]      head_next;

    // Maps a position counted from the head to a slot of the ring.
    function automatic logic [IDX_W-1:0] slot_of(input logic [IDX_W-1:0] head,
                                                 input logic [CNT_W-1:0] l);
        logic [CNT_W:0] s;
        s = (CNT_W+1)'(head) + (CNT_W+1)'(l);
        if (s >= (CNT_W+1)'(QUEUE_DEPTH)) begin
            s = s - (CNT_W+1)'(QUEUE_DEPTH);
        end
        return s[IDX_W-1:0];
    endfunction

    // Delay of a new request: masked to the queue width, zero taken as one.
    always_comb begin
        load_d = DELAY_BITS'(i_in_data.delay);
        if (load_d == '0) begin
            load_d = DELAY_BITS'(1);
        end
    end

    assign tick_val  = r_first ? (r_rdata - DELAY_BITS'(1)) : r_rdata;
    assign sum       = SUM_W'(r_before) + SUM_W'(r_rdata);
    assign head_next = (r_head == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : (r_head + IDX_W'(1));

    // Memory addresses and write data for each command.
    always_comb begin
        rd_l = r_idx;
        wr_l = r_idx;
        we   = 1'b0;
        wd   = r_rdata;
        unique case (i_op)
            DP_TICK_RD: begin
                rd_l = '0;
            end
            DP_TICK_CHK: begin
                we   = r_first;
                wr_l = '0;
                wd   = tick_val;
            end
            DP_MOVE_RD: begin
                rd_l = r_idx - CNT_W'(1);
            end
            DP_MOVE_WR: begin
                we   = 1'b1;
                wr_l = r_idx;
                wd   = r_rdata;
            end
            DP_INS_HI: begin
                we   = 1'b1;
                wr_l = r_pos + CNT_W'(1);
                wd   = r_sum - r_d;
            end
            DP_INS_LO: begin
                we   = 1'b1;
                wr_l = r_pos;
                wd   = r_d - r_before;
            end
            default: begin
                we = 1'b0;
            end
        endcase
    end

    assign rd_addr = slot_of(r_head, rd_l);
    assign wr_addr = slot_of(r_head, wr_l);

    // Delta memory.
    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[wr_addr] <= wd;
        end
        r_rdata <= mem[rd_addr];
    end

    // Head pointer and entry count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_count <= '0;
        end else begin
            if (i_op == DP_TICK_CHK && tick_val == '0) begin
                r_head  <= head_next;
                r_count <= r_count - CNT_W'(1);
            end else if (i_op == DP_INS_LO) begin
                r_count <= r_count + CNT_W'(1);
            end
        end
    end

    // Working registers and the result register.
    always_ff @(posedge i_clk) begin
        unique case (i_op)
            DP_LOAD: begin
                r_d        <= load_d;
                r_idx      <= '0;
                r_before   <= '0;
                r_gone     <= '0;
                r_first    <= 1'b1;
                r_rejected <= (i_in_data.mode == MODE_ADD) && o_status.full;
            end
            DP_TICK_CHK: begin
                r_first <= 1'b0;
                if (tick_val == '0) begin
                    r_gone <= r_gone + CNT_W'(1);
                end
            end
            DP_SRCH_RD: begin
                r_pos <= r_idx;
            end
            DP_SRCH_CHK: begin
                if (o_status.found) begin
                    r_sum <= DELAY_BITS'(sum);
                    r_idx <= r_count;
                end else begin
                    r_before <= DELAY_BITS'(sum);
                    r_idx    <= r_idx + CNT_W'(1);
                end
            end
            DP_MOVE_WR: begin
                r_idx <= r_idx - CNT_W'(1);
            end
            DP_FINISH: begin
                r_out.released <= COUNT_W'(r_gone);
                r_out.waiting  <= COUNT_W'(r_count);
                r_out.rejected <= r_rejected;
            end
            default: begin
                r_first <= r_first;
            end
        endcase
    end

    // Status for the controller.
    always_comb begin
        o_status.empty     = (r_count == '0);
        o_status.full      = (r_count == CNT_W'(QUEUE_DEPTH));
        o_status.tick_zero = (tick_val == '0);
        o_status.last      = (r_count == CNT_W'(1));
        o_status.at_end    = (r_idx == r_count);
        o_status.found     = (sum >= SUM_W'(r_d));
        o_status.move_done = (r_idx == (r_pos + CNT_W'(1)));
    end

    assign o_out_data = r_out;

endmodule

FILE: hdl/timed_wait_delta_queue.sv
// Delta-list timer queue; each memory read takes an address step, then registered data.
// An empty tick or a refused add goes straight to the result; a tick releases expired
// head entries one by one; an add searches for its slot and, unless appended, shifts
// the entries behind it before writing its own delta and the split remainder. The next
// request is taken once the result is handed over; a result still stalled in the output
// register holds the next one back. Reset empties the queue; the memory is not cleared.
`timescale 1ns / 1ps

module timed_wait_delta_queue import twdq_pkg::*; #(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    parameter int DELAY_BITS  = DELAY_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  t_in_item  i_in_data,
    output logic      o_in_stall,
    output logic      o_out_valid,
    output t_out_item o_out_data,
    input  logic      i_out_stall
);

    t_dp_op     op;
    t_dp_status status;

    // Request sequencing.
    twdq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_mode   (i_in_data.mode),
        .i_out_stall (i_out_stall),
        .i_status    (status),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_op        (op)
    );

    // Queue storage and arithmetic.
    twdq_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .DELAY_BITS  (DELAY_BITS)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_op       (op),
        .i_in_data  (i_in_data),
        .o_status   (status),
        .o_out_data (o_out_data)
    );

endmodule

FILE: hdl/twdq_checker.sv
// Port checker for the timer queue, bound to the top level.
// Uses twdq_pkg and the assertion macros of the project header.
`timescale 1ns / 1ps
`include "timed_wait_delta_queue_defines.svh"

module twdq_checker import twdq_pkg::*; #(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input t_in_item  i_in_data,
    input logic      o_in_stall,
    input logic      o_out_valid,
    input t_out_item o_out_data,
    input logic      i_out_stall
);

    // A stalled result stays valid and unchanged.
    `TWDQ_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_data), "stalled result changed")

    // Every accepted request moves the controller out of idle, so the input stalls next.
    `TWDQ_ASSERT_NEXT(a_busy_after_req, i_in_valid && !o_in_stall, o_in_stall, "input not stalled after request")

    // A refused add releases nothing.
    `TWDQ_ASSERT_NOW(a_reject_no_release, o_out_valid && o_out_data.rejected, o_out_data.released == '0, "refused add released entries")

    // A refused add only happens with every slot in use.
    `TWDQ_ASSERT_NOW(a_reject_full, o_out_valid && o_out_data.rejected, o_out_data.waiting == COUNT_W'(QUEUE_DEPTH), "refused add while not full")

endmodule

bind timed_wait_delta_queue twdq_checker #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_checker (.*);
